[hw/rtl/pcx_rle_pkg.sv]
// ---------------------------------------------------------------------------
// pcx_rle_pkg
// Constants and types shared by the pcx run-length encoder files.
// ---------------------------------------------------------------------------
`default_nettype none

package pcx_rle_pkg;

   localparam int unsigned VALUE_W  = 8;
   localparam int unsigned COUNT_W  = 6;
   localparam int unsigned MAX_BYTES = 4;
   localparam int unsigned SLOT_W   = $clog2(MAX_BYTES);
   localparam int unsigned FILL_W   = $clog2(MAX_BYTES + 1);

   localparam logic [COUNT_W-1:0] RUN_MAX       = 6'd63;
   localparam logic [VALUE_W-1:0] RUN_FLAG      = 8'hC0;
   localparam logic [VALUE_W-1:0] LITERAL_LIMIT = 8'd64;

   typedef logic [VALUE_W-1:0] byte_type;

   // one closed run as it goes out: one or two bytes
   typedef struct packed {
      logic [1:0] len;
      byte_type   first;
      byte_type   second;
   } run_bytes_type;

endpackage

`default_nettype wire

[hw/rtl/pcx_rle_encoder_top.sv]
// ---------------------------------------------------------------------------
// pcx_rle_encoder_top
// Run-length encoder for 8-bit scan line pixels, pcx style byte output.
// ---------------------------------------------------------------------------
// the first byte of a transaction shows in the cycle after acceptance
// up to four bytes per pixel drain from the result buffer one by one; each
//    byte stays offered while rsp_stall is high
// a new pixel is taken when the buffer is empty or in the same cycle its last byte is taken
// reset: synchronous, clears the open run and empties the result buffer
`default_nettype none

module pcx_rle_encoder_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_pixel,
   input  wire logic       req_line_end,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [7:0] rsp_code_byte,
   output      logic       rsp_last_of_item,
   output      logic       rsp_closes_line
);

   pcx_rle_pkg::byte_type                       run_value_ff, run_value_in;
   logic [pcx_rle_pkg::COUNT_W-1:0]             run_count_ff, run_count_in;
   pcx_rle_pkg::byte_type                       buf_ff [pcx_rle_pkg::MAX_BYTES];
   pcx_rle_pkg::byte_type                       buf_in [pcx_rle_pkg::MAX_BYTES];
   logic [pcx_rle_pkg::FILL_W-1:0]              fill_ff, fill_in;
   logic [pcx_rle_pkg::SLOT_W-1:0]              slot_ff;
   logic                                        eol_ff;

   pcx_rle_pkg::run_bytes_type                  old_run, new_run;
   logic                                        flush_old, flush_new;
   pcx_rle_pkg::byte_type                       next_value;
   logic [pcx_rle_pkg::COUNT_W-1:0]             next_count;
   logic                                        req_take, rsp_take, at_last;

   function automatic pcx_rle_pkg::run_bytes_type send_run(
      input pcx_rle_pkg::byte_type          v,
      input logic [pcx_rle_pkg::COUNT_W-1:0] c
   );
      pcx_rle_pkg::run_bytes_type r;
      if (c == pcx_rle_pkg::COUNT_W'(1) && v < pcx_rle_pkg::LITERAL_LIMIT) begin
         r.len    = 2'd1;
         r.first  = v;
         r.second = v;
      end else begin
         r.len    = 2'd2;
         r.first  = pcx_rle_pkg::RUN_FLAG | {2'b00, c};
         r.second = v;
      end
      return r;
   endfunction

   // handshake
   assign at_last   = ({1'b0, slot_ff} + pcx_rle_pkg::FILL_W'(1)) == fill_ff;
   assign rsp_valid = fill_ff != '0;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign req_stall = rsp_valid && !(rsp_take && at_last);
   assign req_take  = req_valid && !req_stall;

   assign rsp_code_byte    = buf_ff[slot_ff];
   assign rsp_last_of_item = at_last;
   assign rsp_closes_line  = at_last && eol_ff;

   // run tracking and byte assembly
   always_comb begin
      flush_old = run_count_ff != '0 && req_pixel != run_value_ff;
      old_run   = send_run(run_value_ff, run_count_ff);
      if (!flush_old) begin
         old_run.len = 2'd0;
      end

      if (run_count_ff == '0 || flush_old) begin
         next_value = req_pixel;
         next_count = pcx_rle_pkg::COUNT_W'(1);
      end else begin
         next_value = run_value_ff;
         next_count = run_count_ff + pcx_rle_pkg::COUNT_W'(1);
      end

      flush_new = next_count == pcx_rle_pkg::RUN_MAX || req_line_end;
      new_run   = send_run(next_value, next_count);
      if (!flush_new) begin
         new_run.len = 2'd0;
      end

      run_value_in = next_value;
      run_count_in = flush_new ? '0 : next_count;

      buf_in[3] = new_run.second;
      unique case (old_run.len)
         2'd2: begin
            buf_in[0] = old_run.first;
            buf_in[1] = old_run.second;
            buf_in[2] = new_run.first;
         end
         2'd1: begin
            buf_in[0] = old_run.first;
            buf_in[1] = new_run.first;
            buf_in[2] = new_run.second;
         end
         default: begin
            buf_in[0] = new_run.first;
            buf_in[1] = new_run.second;
            buf_in[2] = new_run.second;
         end
      endcase
      fill_in = pcx_rle_pkg::FILL_W'(old_run.len) + pcx_rle_pkg::FILL_W'(new_run.len);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff <= '0;
         run_count_ff <= '0;
         fill_ff      <= '0;
         slot_ff      <= '0;
      end else if (req_take) begin
         run_value_ff <= run_value_in;
         run_count_ff <= run_count_in;
         fill_ff      <= fill_in;
         slot_ff      <= '0;
      end else if (rsp_take) begin
         if (at_last) begin
            fill_ff <= '0;
            slot_ff <= '0;
         end else begin
            slot_ff <= slot_ff + pcx_rle_pkg::SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         buf_ff <= buf_in;
         eol_ff <= req_line_end;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/pcx_rle_encoder_checker.sv]
// ---------------------------------------------------------------------------
// pcx_rle_encoder_checker
// Port level checks for the pcx run-length encoder, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module pcx_rle_encoder_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_code_byte,
   input wire logic       rsp_last_of_item,
   input wire logic       rsp_closes_line
);

   // stalled transaction stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_byte))
      else $error("stalled rsp transaction dropped or changed");

   // nothing pending right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

   // line close marks the last byte of a transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_closes_line |-> rsp_last_of_item)
      else $error("closes_line without last_of_item");

   // new pixel only taken while the final buffered byte leaves
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && rsp_valid |-> !rsp_stall && rsp_last_of_item)
      else $error("req taken with bytes still pending");

endmodule

bind pcx_rle_encoder_top pcx_rle_encoder_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_code_byte    (rsp_code_byte),
   .rsp_last_of_item (rsp_last_of_item),
   .rsp_closes_line  (rsp_closes_line)
);

`default_nettype wire

[tb/pcx_rle_tb_pkg.sv]
// ---------------------------------------------------------------------------
// pcx_rle_tb_pkg
// Code byte tracker for the pcx run-length encoder testbench. It follows
// the open run of the encoder, builds the expected code bytes of every
// accepted pixel and checks the bytes that come out against them in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

package pcx_rle_tb_pkg;

   import pcx_rle_pkg::*;

   typedef struct packed {
      byte_type code_byte;
      logic     last_of_item;
      logic     closes_line;
   } code_entry_type;

   class pcx_code_tracker;

      byte_type             run_value;
      logic [COUNT_W-1:0]   run_count;
      code_entry_type       pending_codes[$];
      code_entry_type       burst[$];
      int unsigned          fail_count;

      function new();
         run_value  = '0;
         run_count  = '0;
         fail_count = 0;
      endfunction

      // emits the open run as a literal or as a count and value pair
      function void close_run();
         code_entry_type entry;
         entry = '0;
         if (run_count == 1 && run_value < LITERAL_LIMIT) begin
            entry.code_byte = run_value;
            burst.push_back(entry);
         end else begin
            entry.code_byte = RUN_FLAG | {2'b00, run_count};
            burst.push_back(entry);
            entry.code_byte = run_value;
            burst.push_back(entry);
         end
         run_count = '0;
      endfunction

      function void note_pixel(byte_type pixel, logic line_end);
         burst.delete();
         if (run_count != 0 && pixel != run_value)
            close_run();
         if (run_count == 0) begin
            run_value = pixel;
            run_count = 1;
         end else begin
            run_count = run_count + 1'b1;
         end
         if (run_count >= RUN_MAX || line_end)
            close_run();
         if (burst.size() > 0) begin
            burst[burst.size() - 1].last_of_item = 1'b1;
            if (line_end)
               burst[burst.size() - 1].closes_line = 1'b1;
         end
         foreach (burst[i])
            pending_codes.push_back(burst[i]);
      endfunction

      function void check_byte(byte_type code_byte, logic last_of_item, logic closes_line);
         code_entry_type want;
         if (pending_codes.size() == 0) begin
            $error("unexpected code byte %0h", code_byte);
            fail_count++;
            return;
         end
         want = pending_codes.pop_front();
         if (code_byte !== want.code_byte) begin
            $error("code_byte expected %0h actual %0h", want.code_byte, code_byte);
            fail_count++;
         end
         if (last_of_item !== want.last_of_item) begin
            $error("last_of_item expected %0h actual %0h", want.last_of_item, last_of_item);
            fail_count++;
         end
         if (closes_line !== want.closes_line) begin
            $error("closes_line expected %0h actual %0h", want.closes_line, closes_line);
            fail_count++;
         end
      endfunction

   endclass

endpackage

[tb/tb_pcx_rle_encoder_top.sv]
// ---------------------------------------------------------------------------
// tb_pcx_rle_encoder_top
// Testbench of the pcx run-length encoder. A short directed part covers
// literal and run limits, value changes, the four byte case and a run that
// hits the maximum length; a random part sends runs of random value and
// length mixed with noise. Sender idling and receiver stalls change by
// phase, and every output byte is checked against the code byte tracker.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_pcx_rle_encoder_top;

   import pcx_rle_pkg::*;
   import pcx_rle_tb_pkg::*;

   localparam int unsigned RANDOM_ITEMS   = 240;
   localparam int unsigned PHASE_ITEMS    = 60;
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned DRAIN_CYCLES   = 8;

   logic       clock        = 1'b0;
   logic       reset        = 1'b1;
   logic       req_valid    = 1'b0;
   logic       req_stall;
   logic [7:0] req_pixel    = '0;
   logic       req_line_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall    = 1'b0;
   logic [7:0] rsp_code_byte;
   logic       rsp_last_of_item;
   logic       rsp_closes_line;

   int unsigned idle_pct   = 0;
   int unsigned stall_pct  = 0;
   int unsigned item_count = 0;
   int unsigned quiet_cycles = 0;

   pcx_code_tracker tracker;

   pcx_rle_encoder_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .req_line_end     (req_line_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_code_byte    (rsp_code_byte),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_closes_line  (rsp_closes_line)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // transaction monitor on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_stall === 1'b0)
            tracker.note_pixel(req_pixel, req_line_end);
         if (rsp_valid === 1'b1 && !rsp_stall)
            tracker.check_byte(rsp_code_byte, rsp_last_of_item, rsp_closes_line);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_pcx_rle_encoder_top NOT OK");
            $finish;
         end
      end
   end

   task automatic set_phase(input int unsigned phase);
      case (phase % 4)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 82; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 82; end
         default: begin idle_pct = 29; stall_pct = 29; end
      endcase
   endtask

   // called at a rising edge; returns at the edge that accepts the pixel
   task automatic send_pixel(input byte_type pixel, input logic line_end);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel    <= pixel;
      req_line_end <= line_end;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      item_count++;
   endtask

   task automatic send_run(input byte_type pixel, input int unsigned len, input logic line_end);
      for (int unsigned i = 0; i < len; i++)
         send_pixel(pixel, line_end && (i == len - 1));
   endtask

   initial begin
      int unsigned base;
      int unsigned kind;
      byte_type    value;
      tracker = new();
      set_phase(0);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // literal and run limits, single pixel lines
      send_pixel(8'h00, 1'b1);
      send_pixel(8'h3F, 1'b1);
      send_pixel(8'h40, 1'b1);
      send_pixel(8'hFF, 1'b1);
      // value change inside a line
      send_run(8'hAA, 3, 1'b0);
      send_run(8'h10, 2, 1'b1);
      // change and line end together: four bytes
      send_run(8'h80, 2, 1'b0);
      send_pixel(8'hFF, 1'b1);
      send_pixel(8'h21, 1'b0);
      send_pixel(8'h22, 1'b0);
      send_pixel(8'h23, 1'b1);
      send_pixel(8'h3F, 1'b0);
      send_pixel(8'h40, 1'b1);
      // run hits the maximum length, one pixel left for the line end
      send_run(8'h05, 64, 1'b1);

      base = item_count;
      while (item_count < base + RANDOM_ITEMS) begin
         set_phase((item_count - base) / PHASE_ITEMS);
         kind  = $urandom_range(99);
         value = $urandom_range(1) ? byte_type'($urandom_range(63))
                                   : byte_type'($urandom_range(255));
         if (kind < 12)
            send_pixel(byte_type'($urandom_range(255)), logic'($urandom_range(1)));
         else if (kind < 15)
            send_run(value, $urandom_range(58, 68), $urandom_range(99) < 50);
         else
            send_run(value, $urandom_range(1, 6), $urandom_range(99) < 30);
      end
      req_valid <= 1'b0;

      while (tracker.pending_codes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.fail_count == 0)
         $display("tb_pcx_rle_encoder_top OK");
      else
         $display("tb_pcx_rle_encoder_top NOT OK");
      $finish;
   end

endmodule
